[rtl/core/mjmc_pkg.sv]
// ----------------------------------------------------------------------------
// mjmc_pkg
// Shared types and constants for the PES deframer / JPEG marker collator.
// ----------------------------------------------------------------------------
`default_nettype none

package mjmc_pkg;

    localparam int POS_W = 17;

    // result kinds
    localparam logic [1:0] KIND_TIMESTAMPS = 2'd0;
    localparam logic [1:0] KIND_MARKER     = 2'd1;
    localparam logic [1:0] KIND_FRAME_END  = 2'd2;
    localparam logic [1:0] KIND_HDR_ERROR  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_IGNORE_LOW  = 2'd0;
    localparam logic [1:0] CFG_IGNORE_HIGH = 2'd1;
    localparam logic [1:0] CFG_FRAME_START = 2'd2;

    localparam logic [7:0] CFG_IGNORE_LOW_RST  = 8'd0;
    localparam logic [7:0] CFG_IGNORE_HIGH_RST = 8'd191;
    localparam logic [7:0] CFG_FRAME_START_RST = 8'd216;

    // packet byte positions
    localparam logic [POS_W-1:0] POS_FIRST     = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd5;
    localparam logic [POS_W-1:0] POS_FLAGS     = 17'd7;
    localparam logic [POS_W-1:0] POS_HDR_LEN   = 17'd8;
    localparam logic [POS_W-1:0] POS_HDR_FIRST = 17'd9;
    localparam logic [POS_W-1:0] POS_PTS_LAST  = 17'd13;
    localparam logic [POS_W-1:0] POS_DTS_LAST  = 17'd18;

    localparam logic [1:0] TS_FLAGS_DTS_ONLY = 2'b01;
    localparam logic [1:0] TS_FLAGS_BOTH     = 2'b11;
    localparam logic [7:0] MARKER_PREFIX     = 8'hFF;

    typedef struct packed {
        logic [7:0] ignore_low;
        logic [7:0] ignore_high;
        logic [7:0] frame_start_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [23:0] marker_offset;
        logic [23:0] frame_length;
        logic [32:0] pts;
        logic        pts_valid;
        logic [32:0] dts;
        logic        dts_valid;
    } res_t;

    // drop the marker bits of the 5-byte PES time stamp field
    function automatic logic [32:0] ts_extract(input logic [39:0] v);
        ts_extract = {v[35:33], v[31:17], v[15:1]};
    endfunction

endpackage

`default_nettype wire

[rtl/core/mjmc_parser.sv]
// ----------------------------------------------------------------------------
// mjmc_parser
// Per-byte PES header tracking, time stamp capture and marker scan.
// State updates in the cycle the registered byte is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module mjmc_parser #(
    parameter int FRAME_SIZE_BITS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_bstart,
    input  wire mjmc_pkg::cfg_t cfg,
    output mjmc_pkg::res_t     res,
    output logic               res_valid
);
    import mjmc_pkg::*;

    localparam int FSB   = FRAME_SIZE_BITS;
    localparam int EXT_W = (FSB > 24) ? FSB : 24;
    localparam logic [FSB-1:0] FS_ZERO = '0;
    localparam logic [FSB-1:0] FS_ONE  = FSB'(1);
    localparam logic [FSB-1:0] FS_TWO  = FSB'(2);
    localparam logic [FSB-1:0] FS_MAX  = {FSB{1'b1}};

    logic [POS_W-1:0] pos_reg;
    logic [15:0]      plen_reg;
    logic [7:0]       hdl_reg;
    logic [1:0]       tsf_reg;
    logic [39:0]      pts_reg;
    logic [39:0]      dts_reg;
    logic             prev_ff_reg;
    logic [FSB-1:0]   fsize_reg;
    logic             skip_reg;

    logic [POS_W-1:0] pos, pos_next, hdr_end, pkt_end;
    logic             skip, first;
    logic [15:0]      plen_base, plen_next;
    logic [7:0]       hdl_base, hdl_next;
    logic [1:0]       tsf_base, tsf_next;
    logic [39:0]      pts_base, dts_base, pts_next, dts_next;
    logic             prev_base, prev_ff_next;
    logic             in_hdr, hdr_err, ts_rep, payload, ignored, mk, fend, pkt_done;
    logic [FSB-1:0]   f1, fsize_next, moff;
    logic [EXT_W-1:0] flen_ext, moff_ext;
    logic             pv, dv;

    always_comb begin
        pos   = in_bstart ? POS_FIRST : pos_reg;
        skip  = in_bstart ? 1'b0 : skip_reg;
        first = (pos == POS_FIRST);

        // packet start clears the per-packet state
        plen_base = first ? 16'd0 : plen_reg;
        hdl_base  = first ? 8'd0  : hdl_reg;
        tsf_base  = first ? 2'd0  : tsf_reg;
        pts_base  = first ? 40'd0 : pts_reg;
        dts_base  = first ? 40'd0 : dts_reg;
        prev_base = first ? 1'b0  : prev_ff_reg;

        if (pos == POS_LEN_HI) begin
            plen_next = {in_byte, 8'd0};
        end else if (pos == POS_LEN_LO) begin
            plen_next = {plen_base[15:8], in_byte};
        end else begin
            plen_next = plen_base;
        end
        tsf_next = (pos == POS_FLAGS)   ? in_byte[7:6] : tsf_base;
        hdl_next = (pos == POS_HDR_LEN) ? in_byte      : hdl_base;

        hdr_end = POS_W'(hdl_next) + POS_HDR_LEN;
        in_hdr  = (pos >= POS_HDR_FIRST) && (pos <= hdr_end);

        pts_next = pts_base;
        dts_next = dts_base;
        for (int k = 0; k < 5; k++) begin
            if (in_hdr && pos == POS_PTS_LAST - POS_W'(k)) begin
                pts_next[8*k +: 8] = pts_base[8*k +: 8] | in_byte;
            end
            if (in_hdr && pos == POS_DTS_LAST - POS_W'(k)) begin
                dts_next[8*k +: 8] = dts_base[8*k +: 8] | in_byte;
            end
        end

        hdr_err = (pos == POS_FLAGS) && (in_byte[7:6] == TS_FLAGS_DTS_ONLY);
        ts_rep  = (pos >= POS_HDR_LEN) && (pos == hdr_end);
        payload = (pos >= POS_HDR_FIRST) && (pos > hdr_end);

        ignored = (in_byte >= cfg.ignore_low) && (in_byte <= cfg.ignore_high);
        f1      = (fsize_reg != FS_MAX) ? fsize_reg + FS_ONE : fsize_reg;
        mk      = payload && prev_base && (in_byte != MARKER_PREFIX) && !ignored;
        fend    = mk && (in_byte == cfg.frame_start_code) && (fsize_reg >= FS_TWO);
        moff    = (fsize_reg == FS_ZERO) ? FS_ZERO : fsize_reg - FS_ONE;
        flen_ext = EXT_W'(f1 - FS_TWO);
        moff_ext = EXT_W'(moff);

        prev_ff_next = payload ? (in_byte == MARKER_PREFIX) : prev_base;
        if (hdr_err) begin
            fsize_next = FS_ZERO;
        end else if (fend) begin
            fsize_next = FS_TWO;
        end else if (payload) begin
            fsize_next = f1;
        end else begin
            fsize_next = fsize_reg;
        end

        pkt_end  = {1'b0, plen_next} + POS_LEN_LO;
        pkt_done = (pos >= POS_LEN_LO) && (pos >= pkt_end);
        pos_next = (hdr_err || pkt_done) ? POS_FIRST : pos + POS_W'(1);

        pv = tsf_next[1];
        dv = (tsf_next == TS_FLAGS_BOTH);

        res = '0;
        if (hdr_err) begin
            res.kind = KIND_HDR_ERROR;
        end else if (ts_rep) begin
            res.kind      = KIND_TIMESTAMPS;
            res.pts       = pv ? ts_extract(pts_next) : 33'd0;
            res.pts_valid = pv;
            res.dts       = dv ? ts_extract(dts_next) : 33'd0;
            res.dts_valid = dv;
        end else if (fend) begin
            res.kind         = KIND_FRAME_END;
            res.code         = in_byte;
            res.frame_length = flen_ext[23:0];
        end else begin
            res.kind          = KIND_MARKER;
            res.code          = in_byte;
            res.marker_offset = moff_ext[23:0];
        end
        res_valid = advance && !skip && (hdr_err || ts_rep || mk);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_FIRST;
            plen_reg    <= 16'd0;
            hdl_reg     <= 8'd0;
            tsf_reg     <= 2'd0;
            pts_reg     <= 40'd0;
            dts_reg     <= 40'd0;
            prev_ff_reg <= 1'b0;
            fsize_reg   <= FS_ZERO;
            skip_reg    <= 1'b0;
        end else if (advance && !skip) begin
            pos_reg     <= pos_next;
            plen_reg    <= plen_next;
            hdl_reg     <= hdl_next;
            tsf_reg     <= tsf_next;
            pts_reg     <= pts_next;
            dts_reg     <= dts_next;
            prev_ff_reg <= prev_ff_next;
            fsize_reg   <= fsize_next;
            skip_reg    <= hdr_err;
        end
    end

    // a header error parks the parser until the next buffer start
    a_err_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_HDR_ERROR |=> skip_reg && fsize_reg == FS_ZERO)
        else $error("header error did not set skip");

    a_skip_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg && !in_bstart |=> $stable(fsize_reg) && $stable(pos_reg))
        else $error("state moved while skipping buffer");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_FRAME_END |=> fsize_reg == FS_TWO)
        else $error("frame size not restarted after frame end");

endmodule

`default_nettype wire

[rtl/core/mjmc_out_reg.sv]
// ----------------------------------------------------------------------------
// mjmc_out_reg
// Result register on the master side; frees itself as the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mjmc_out_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire mjmc_pkg::res_t res,
    input  wire logic       m_ready,
    output logic            m_valid,
    output mjmc_pkg::res_t  m_res,
    output logic            free
);
    import mjmc_pkg::*;

    logic valid_reg;
    res_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;
    assign free    = !valid_reg || m_ready;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("result register loaded while holding an untaken word");

endmodule

`default_nettype wire

[rtl/core/pes_mjpeg_marker_collator.sv]
// ----------------------------------------------------------------------------
// pes_mjpeg_marker_collator
// PES deframer with JPEG marker scan: reports time stamps, markers, frame
// ends and malformed headers for a byte stream of PES packets.
//
//   channel  dir  width     contents
//   s_       in   8 + 1     one stream byte, buffer start flag
//   m_       out  128 + 2   one report word (kind in tuser)
//   cfg_     in   2 + 8     ignore range low/high, frame start code
//
// One byte per cycle sustained while m_tready stays high. A byte is first
// registered in the input register, and its report is written into the result
// register when the parser consumes it, raising m_tvalid. Bytes that cause no report leave no word.
// aresetn is synchronous; state and configuration go to their reset values.
// A word waiting on m_ with m_tready low holds the parser; s_tready drops
// while the input register is full and the parser is held.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_mjpeg_marker_collator #(
    parameter int FRAME_SIZE_BITS = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]   s_tuser,   // [0] buffer_start

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] code, [31:8] marker_offset, [55:32] frame_length, [88:56] pts,
    // [89] pts_valid, [122:90] dts, [123] dts_valid, [127:124] zero
    output logic [127:0]      m_tdata,
    output logic [1:0]        m_tuser,   // [1:0] kind

    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);
    import mjmc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_bstart_reg;
    logic       advance, out_free, res_valid;
    res_t       res, out_res;
    cfg_t       cfg_reg;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg   <= s_tdata;
            in_bstart_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ignore_low       <= CFG_IGNORE_LOW_RST;
            cfg_reg.ignore_high      <= CFG_IGNORE_HIGH_RST;
            cfg_reg.frame_start_code <= CFG_FRAME_START_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IGNORE_LOW:  cfg_reg.ignore_low       <= cfg_data;
                CFG_IGNORE_HIGH: cfg_reg.ignore_high      <= cfg_data;
                CFG_FRAME_START: cfg_reg.frame_start_code <= cfg_data;
                default: ;
            endcase
        end
    end

    mjmc_parser #(
        .FRAME_SIZE_BITS(FRAME_SIZE_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_byte   (in_byte_reg),
        .in_bstart (in_bstart_reg),
        .cfg       (cfg_reg),
        .res       (res),
        .res_valid (res_valid)
    );

    mjmc_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res     (res),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_res   (out_res),
        .free    (out_free)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {4'd0, out_res.dts_valid, out_res.dts, out_res.pts_valid, out_res.pts,
                      out_res.frame_length, out_res.marker_offset, out_res.code};

    // a held input word stays while the result side is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input word lost during output stall");

    a_report_needs_input: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> in_valid_reg)
        else $error("report without a word in the input register");

endmodule

`default_nettype wire

[test/collator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// collator_checker
// Monitors the byte, report and register channels of the PES marker collator.
// A byte-level model of the deframer and marker scan predicts each report
// word, and every accepted report is compared with it field by field.
// ----------------------------------------------------------------------------
module collator_checker
    import mjmc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    output int           n_fail,
    output int           n_pending,
    output int           n_stamps,
    output int           n_markers,
    output int           n_frame_ends,
    output int           n_hdr_errors
);

    localparam logic [23:0] SIZE_CAP = 24'hFF_FFFF;

    // register copies
    logic [7:0]       ign_lo;
    logic [7:0]       ign_hi;
    logic [7:0]       start_code;

    // deframer state
    logic [POS_W-1:0] pkt_pos;
    logic [15:0]      pkt_len;
    logic [7:0]       hdr_len;
    logic [1:0]       ts_flags;
    logic [39:0]      pts_sr;
    logic [39:0]      dts_sr;
    logic             prev_ff;
    logic             skipping;
    logic [23:0]      frame_sz;

    res_t             reports_due[$];

    task automatic clear_state();
        ign_lo     = CFG_IGNORE_LOW_RST;
        ign_hi     = CFG_IGNORE_HIGH_RST;
        start_code = CFG_FRAME_START_RST;
        pkt_pos    = '0;
        pkt_len    = '0;
        hdr_len    = '0;
        ts_flags   = '0;
        pts_sr     = '0;
        dts_sr     = '0;
        prev_ff    = 1'b0;
        skipping   = 1'b0;
        frame_sz   = '0;
        reports_due.delete();
    endtask

    // one stream byte through the deframer; hit says whether it leaves a word
    task automatic scan_byte(input logic [7:0] b, input logic bstart,
                             output logic hit, output res_t rep);
        int unsigned pos;
        int unsigned hdr_end;
        int unsigned pkt_end;
        logic [23:0] f1;
        logic        ignored;
        hit = 1'b0;
        rep = '0;
        if (bstart) begin
            skipping = 1'b0;
            pkt_pos  = '0;
        end
        if (skipping)
            return;

        pos = pkt_pos;
        if (pos == POS_FIRST) begin
            pkt_len  = '0;
            hdr_len  = '0;
            ts_flags = '0;
            pts_sr   = '0;
            dts_sr   = '0;
            prev_ff  = 1'b0;
        end

        if (pos == POS_LEN_HI) begin
            pkt_len = {b, 8'h00};
        end else if (pos == POS_LEN_LO) begin
            pkt_len[7:0] = b;
        end else if (pos == POS_FLAGS) begin
            ts_flags = b[7:6];
            if (ts_flags == TS_FLAGS_DTS_ONLY) begin
                // drop the frame and the rest of this buffer
                rep.kind = KIND_HDR_ERROR;
                hit      = 1'b1;
                frame_sz = '0;
                skipping = 1'b1;
                pkt_pos  = '0;
                return;
            end
        end else if (pos == POS_HDR_LEN) begin
            hdr_len = b;
        end

        hdr_end = POS_HDR_LEN + hdr_len;
        if (pos >= POS_HDR_FIRST && pos <= hdr_end) begin
            if (pos <= POS_PTS_LAST)
                pts_sr |= 40'(b) << (8 * (POS_PTS_LAST - pos));
            else if (pos <= POS_DTS_LAST)
                dts_sr |= 40'(b) << (8 * (POS_DTS_LAST - pos));
        end

        if (pos >= POS_HDR_LEN && pos == hdr_end) begin
            rep.kind      = KIND_TIMESTAMPS;
            rep.pts_valid = ts_flags[1];
            rep.dts_valid = (ts_flags == TS_FLAGS_BOTH);
            // 5-byte stamp fields carry marker bits at 32, 16 and 0
            if (rep.pts_valid)
                rep.pts = {pts_sr[35:33], pts_sr[31:17], pts_sr[15:1]};
            if (rep.dts_valid)
                rep.dts = {dts_sr[35:33], dts_sr[31:17], dts_sr[15:1]};
            hit = 1'b1;
        end else if (pos >= POS_HDR_FIRST && pos > hdr_end) begin
            ignored = (b >= ign_lo) && (b <= ign_hi);
            f1 = (frame_sz == SIZE_CAP) ? frame_sz : frame_sz + 24'd1;
            if (prev_ff && b != MARKER_PREFIX && !ignored) begin
                rep.code = b;
                hit      = 1'b1;
                if (b == start_code && frame_sz >= 24'd2) begin
                    rep.kind         = KIND_FRAME_END;
                    rep.frame_length = f1 - 24'd2;
                    frame_sz         = 24'd2;
                end else begin
                    rep.kind          = KIND_MARKER;
                    rep.marker_offset = (frame_sz >= 24'd1) ? frame_sz - 24'd1 : 24'd0;
                    frame_sz          = f1;
                end
            end else begin
                frame_sz = f1;
            end
            prev_ff = (b == MARKER_PREFIX);
        end

        pkt_end = pkt_len + 32'd5;
        if (pos >= POS_LEN_LO && pos >= pkt_end)
            pkt_pos = '0;
        else
            pkt_pos = POS_W'(pos + 1);
    endtask

    task automatic check_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
        if (want !== got) begin
            $error("report field %s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin : watch
        res_t seen;
        res_t want;
        res_t rep;
        logic hit;
        if (!aresetn) begin
            clear_state();
            n_stamps     = 0;
            n_markers    = 0;
            n_frame_ends = 0;
            n_hdr_errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.kind          = m_tuser;
                seen.code          = m_tdata[7:0];
                seen.marker_offset = m_tdata[31:8];
                seen.frame_length  = m_tdata[55:32];
                seen.pts           = m_tdata[88:56];
                seen.pts_valid     = m_tdata[89];
                seen.dts           = m_tdata[122:90];
                seen.dts_valid     = m_tdata[123];
                case (seen.kind)
                    KIND_TIMESTAMPS: n_stamps++;
                    KIND_MARKER:     n_markers++;
                    KIND_FRAME_END:  n_frame_ends++;
                    default:         n_hdr_errors++;
                endcase
                if (reports_due.size() == 0) begin
                    $error("unexpected report word: kind %0d code %0h",
                           seen.kind, seen.code);
                    n_fail++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("kind", want.kind, seen.kind);
                    check_field("code", want.code, seen.code);
                    check_field("marker_offset", want.marker_offset, seen.marker_offset);
                    check_field("frame_length", want.frame_length, seen.frame_length);
                    check_field("pts", want.pts, seen.pts);
                    check_field("pts_valid", want.pts_valid, seen.pts_valid);
                    check_field("dts", want.dts, seen.dts);
                    check_field("dts_valid", want.dts_valid, seen.dts_valid);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IGNORE_LOW:  ign_lo = cfg_data;
                    CFG_IGNORE_HIGH: ign_hi = cfg_data;
                    CFG_FRAME_START: start_code = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tuser[0], hit, rep);
                if (hit)
                    reports_due.push_back(rep);
            end
        end
        n_pending = reports_due.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the PES marker collator: PES packets with random headers,
// time stamps and marker-rich payloads, plus malformed and cut packets and
// line noise, under several ignore ranges and frame start codes. Both sides
// idle at random; a long hold-off on the report side backs up the byte input.
// ----------------------------------------------------------------------------
module tb;
    import mjmc_pkg::*;

    localparam int          HOLD_CYCLES = 120;
    localparam int          PHASE_ITEMS = 240;
    localparam logic [7:0]  APP0_CODE   = 8'hE0;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic [7:0]   s_tdata   = '0;
    logic [0:0]   s_tuser   = '0;
    logic         m_tready  = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [7:0]   cfg_data  = '0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [127:0] m_tdata;
    wire  [1:0]   m_tuser;

    int n_fail;
    int n_pending;
    int n_stamps;
    int n_markers;
    int n_frame_ends;
    int n_hdr_errors;

    int         n_sent    = 0;
    bit         steady    = 1'b0;   // no idling on either side
    bit         hold_req  = 1'b0;
    bit         need_sync = 1'b1;
    logic [7:0] cur_start = CFG_FRAME_START_RST;
    logic [7:0] pes_bytes[$];

    pes_mjpeg_marker_collator u_dut (.*);

    collator_checker u_check (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("pes_mjpeg_marker_collator verification failed");
        $finish;
    end

    // report side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic bs);
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= bs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic send_run(input logic sync, input int count);
        for (int i = 0; i < count && i < pes_bytes.size(); i++)
            send_byte(pes_bytes[i], (i == 0) ? sync : 1'b0);
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return MARKER_PREFIX;
            3:       return cur_start;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_packet(input logic [1:0] flags, input int hdr, input int plen,
                                input int len_field);
        pes_bytes.delete();
        pes_bytes.push_back(8'h00);
        pes_bytes.push_back(8'h00);
        pes_bytes.push_back(8'h01);
        pes_bytes.push_back(8'($urandom));
        pes_bytes.push_back(len_field[15:8]);
        pes_bytes.push_back(len_field[7:0]);
        pes_bytes.push_back(8'($urandom));
        pes_bytes.push_back({flags, 6'($urandom)});
        pes_bytes.push_back(8'(hdr));
        repeat (hdr) pes_bytes.push_back(8'($urandom));
        repeat (plen) pes_bytes.push_back(payload_byte());
    endtask

    task automatic random_packet();
        int         sel;
        int         hdr;
        int         plen;
        int         len_field;
        logic [1:0] flags;
        logic       sync;
        sel   = $urandom_range(0, 99);
        flags = ($urandom_range(0, 2) == 0) ? 2'b00 : {1'b1, 1'($urandom)};
        if ($urandom_range(0, 3) == 0)
            hdr = $urandom_range(0, 12);
        else
            hdr = (flags == TS_FLAGS_BOTH) ? 10 : 5;
        if ($urandom_range(0, 49) == 0)
            plen = $urandom_range(200, 300);
        else
            plen = $urandom_range(0, 24);
        len_field = 3 + hdr + plen;
        sync      = need_sync || ($urandom_range(0, 3) == 0);
        need_sync = 1'b0;
        if (sel < 70) begin
            build_packet(flags, hdr, plen, len_field);
            send_run(sync, pes_bytes.size());
        end else if (sel < 78) begin
            // short length field: header overrun or payload cut by the length
            len_field = $urandom_range(0, len_field);
            build_packet(flags, hdr, plen, len_field);
            send_run(sync, len_field + 6);
        end else if (sel < 84) begin
            // buffer ends mid packet
            build_packet(flags, hdr, plen, len_field);
            send_run(sync, $urandom_range(1, pes_bytes.size()));
            need_sync = 1'b1;
        end else if (sel < 88) begin
            // DTS without PTS; trailing bytes fall into the skipped buffer
            build_packet(TS_FLAGS_DTS_ONLY, hdr, plen, len_field);
            send_run(sync, 8 + $urandom_range(0, 6));
            need_sync = 1'b1;
        end else begin
            repeat ($urandom_range(4, 20))
                send_byte(8'($urandom), $urandom_range(0, 9) == 0);
            need_sync = 1'b1;
        end
    endtask

    task automatic run_phase(input int items);
        int stop;
        stop = n_sent + items;
        while (n_sent < stop) random_packet();
    endtask

    // registers change only with the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (n_pending != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] lo, input logic [7:0] hi,
                                input logic [7:0] start);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IGNORE_LOW;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= CFG_IGNORE_HIGH;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_index <= CFG_FRAME_START;
        cfg_data  <= start;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_start = start;
    endtask

    task automatic directed();
        // zero packet length: six bytes, no report
        build_packet(2'b00, 0, 0, 0);
        send_run(1'b1, 6);
        // DTS-only flags: error word, next byte is dropped
        build_packet(TS_FLAGS_DTS_ONLY, 0, 0, 3);
        send_run(1'b0, 8);
        send_byte(MARKER_PREFIX, 1'b0);
        // empty header, then FF FF APP0 and a frame start on a non-empty frame
        build_packet(2'b00, 0, 0, 8);
        pes_bytes.push_back(MARKER_PREFIX);
        pes_bytes.push_back(MARKER_PREFIX);
        pes_bytes.push_back(APP0_CODE);
        pes_bytes.push_back(MARKER_PREFIX);
        pes_bytes.push_back(CFG_FRAME_START_RST);
        send_run(1'b1, pes_bytes.size());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed();
        run_phase(PHASE_ITEMS);

        // nothing ignored, code 00 starts frames; report side held off
        settle();
        program_regs(8'hFF, 8'h00, 8'h00);
        hold_req = 1'b1;
        build_packet(2'b00, 0, 80, 83);
        send_run(1'b1, pes_bytes.size());
        run_phase(PHASE_ITEMS);

        // every code ignored
        settle();
        program_regs(8'h00, 8'hFF, 8'hFF);
        run_phase(PHASE_ITEMS / 2);

        settle();
        program_regs(8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(PHASE_ITEMS);

        settle();
        program_regs(8'hC0, 8'hCF, CFG_FRAME_START_RST);
        steady = 1'b1;
        run_phase(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        for (int w = 0; w < 4000 && n_pending != 0; w++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (n_pending != 0)
            $error("%0d expected report words never arrived", n_pending);

        $display("sent %0d stream bytes across five register settings", n_sent);
        $display("reports: %0d time stamp, %0d marker, %0d frame end, %0d header error",
                 n_stamps, n_markers, n_frame_ends, n_hdr_errors);
        if (n_fail == 0 && n_pending == 0)
            $display("pes_mjpeg_marker_collator verification clean");
        else
            $display("pes_mjpeg_marker_collator verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mjmc_pkg.sv
rtl/core/mjmc_parser.sv
rtl/core/mjmc_out_reg.sv
rtl/core/pes_mjpeg_marker_collator.sv
test/collator_checker.sv
test/tb.sv
